>>> hdl/mse_pkg.sv
// Package for the MIPS subset executor: opcode/funct codes, exception codes,
// decoded-instruction struct and FSM state types. No dependencies.
package mse_pkg;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2B;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1A;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_SLT  = 6'h2A;

    localparam logic [1:0] EXC_NONE  = 2'd0;
    localparam logic [1:0] EXC_OVF   = 2'd1;
    localparam logic [1:0] EXC_ADDR  = 2'd2;
    localparam logic [1:0] EXC_UNIMP = 2'd3;

    typedef enum logic [4:0] {
        K_UNIMP, K_ADD, K_SUB, K_AND, K_OR, K_XOR, K_SLT, K_SLL, K_SRL, K_ROTR,
        K_MULT, K_DIV, K_MFHI, K_MFLO, K_JR, K_ADDI, K_LUI, K_LW, K_SW,
        K_BEQ, K_BNE, K_BLEZ, K_BGTZ
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [31:0] imm;
    } dec_t;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_EXEC, S_MUL2, S_DIVI, S_DIVF, S_MEM, S_LDW, S_STW,
        S_CLR, S_DONE
    } bst_t;

endpackage

>>> hdl/mips_subset_execute_step.sv
// Top level of the MIPS subset executor: joins decoding front and execution back.
// Depends on mse_pkg, mse_front and mse_back.
// Sequence: IDLE, READ, EXEC, DONE for most instructions; MULT adds MUL2, SW adds STW,
//   LW adds MEM and LDW, DIV adds DIVI, the one-bit-per-cycle restoring divider, and DIVF.
// The back part runs one instruction at a time and takes a new one only once the last result
//   is taken, while the front queue holds up to two waiting beats.
// Reset: registers, HI, LO and PC clear at once; a clearing pass then zeroes every word of
//   data memory before the first instruction starts.
module mips_subset_execute_step #(
    parameter int MEM_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    output logic        stall_in,
    input  logic [31:0] instr_word,
    output logic        valid_out,
    input  logic        stall_out,
    output logic [31:0] next_pc,
    output logic        reg_written,
    output logic [4:0]  dest_index,
    output logic [31:0] dest_value,
    output logic [1:0]  exception_code
);
    import mse_pkg::*;

    logic q_valid;
    logic q_pop;
    dec_t q_dec;

    // decode and queue beats
    mse_front u_front (
        .clk(clk), .rst_n(rst_n), .valid_in(valid_in), .stall_in(stall_in),
        .instr_word(instr_word), .q_valid(q_valid), .q_dec(q_dec), .q_pop(q_pop)
    );

    // execute, hold each result until taken
    mse_back #(.MEM_BYTES(MEM_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_dec(q_dec), .q_pop(q_pop),
        .valid_out(valid_out), .stall_out(stall_out), .next_pc(next_pc),
        .reg_written(reg_written), .dest_index(dest_index), .dest_value(dest_value),
        .exception_code(exception_code)
    );

endmodule

>>> hdl/mse_front.sv
// Front part: accepts instruction words, decodes them and feeds a two-entry queue.
// Depends on mse_pkg.
module mse_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    output logic            stall_in,
    input  logic [31:0]     instr_word,
    output logic            q_valid,
    output mse_pkg::dec_t   q_dec,
    input  logic            q_pop
);
    import mse_pkg::*;

    dec_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    dec_t       d;
    logic       push;

    always_comb
    begin
        d.rs   = instr_word[25:21];
        d.rt   = instr_word[20:16];
        d.rd   = instr_word[15:11];
        d.sh   = instr_word[10:6];
        d.imm  = {{16{instr_word[15]}}, instr_word[15:0]};
        d.kind = K_UNIMP;
        case (instr_word[31:26])
            OP_SPECIAL:
            begin
                case (instr_word[5:0])
                    FN_ADD:  d.kind = K_ADD;
                    FN_SUB:  d.kind = K_SUB;
                    FN_AND:  d.kind = K_AND;
                    FN_OR:   d.kind = K_OR;
                    FN_XOR:  d.kind = K_XOR;
                    FN_SLT:  d.kind = K_SLT;
                    FN_SLL:  d.kind = K_SLL;
                    FN_SRL:  d.kind = instr_word[21] ? K_ROTR : K_SRL;
                    FN_MULT: d.kind = K_MULT;
                    FN_DIV:  d.kind = K_DIV;
                    FN_MFHI: d.kind = K_MFHI;
                    FN_MFLO: d.kind = K_MFLO;
                    FN_JR:   d.kind = K_JR;
                    default: d.kind = K_UNIMP;
                endcase
            end
            OP_ADDI: d.kind = K_ADDI;
            OP_LUI:  d.kind = K_LUI;
            OP_LW:   d.kind = K_LW;
            OP_SW:   d.kind = K_SW;
            OP_BEQ:  d.kind = K_BEQ;
            OP_BNE:  d.kind = K_BNE;
            OP_BLEZ: d.kind = K_BLEZ;
            OP_BGTZ: d.kind = K_BGTZ;
            default: d.kind = K_UNIMP;
        endcase
    end

    assign stall_in = (cnt_reg == 2'd2);
    assign push     = valid_in && !stall_in;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_dec    = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= d;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overfilled");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("queue count out of range");

endmodule

>>> hdl/mse_back.sv
// Back part: register file, HI/LO, PC, partial-product multiply, iterative divide, data memory.
// Depends on mse_pkg.
module mse_back #(
    parameter int MEM_BYTES = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  mse_pkg::dec_t   q_dec,
    output logic            q_pop,
    output logic            valid_out,
    input  logic            stall_out,
    output logic [31:0]     next_pc,
    output logic            reg_written,
    output logic [4:0]      dest_index,
    output logic [31:0]     dest_value,
    output logic [1:0]      exception_code
);
    import mse_pkg::*;

    localparam int WORDS = (MEM_BYTES / 4 > 1) ? MEM_BYTES / 4 : 2;
    localparam int AW    = $clog2(WORDS);

    bst_t st_reg, st_next;
    logic [31:0] rf_reg [32];
    logic [31:0] mem [WORDS];
    logic [31:0] hi_reg, lo_reg, pc_reg;
    dec_t        d_reg;
    logic [31:0] a_reg, b_reg;
    logic [31:0] npc_reg;
    logic        wr_reg;
    logic [4:0]  widx_reg;
    logic [31:0] wval_reg;
    logic [1:0]  exc_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] maddr_reg;
    logic [31:0] rdata_reg;
    logic [63:0] prod_full;
    logic [31:0] pll_reg, plh_reg, phl_reg, phh_reg;
    // divider: magnitudes and partial remainder
    logic [31:0] dq_reg, dd_reg, drem_reg;
    logic [5:0]  dcnt_reg;
    logic        qneg_reg, rneg_reg;

    logic [31:0] seq, btgt, sum, dif, ea, lui;
    logic        ovf_add, ovf_sub, ovf_addi, addr_ok;
    logic [32:0] trial;

    assign seq  = pc_reg + 32'd4;
    assign btgt = seq + {d_reg.imm[29:0], 2'b00};
    assign sum  = a_reg + b_reg;
    assign dif  = a_reg - b_reg;
    assign ea   = a_reg + d_reg.imm;
    assign lui  = {d_reg.imm[15:0], 16'h0000};
    assign ovf_add  = (a_reg[31] ~^ b_reg[31]) && (sum[31] != a_reg[31]);
    assign ovf_sub  = (a_reg[31] ^ b_reg[31]) && (dif[31] != a_reg[31]);
    assign ovf_addi = (a_reg[31] ~^ d_reg.imm[31]) && (ea[31] != a_reg[31]);
    assign addr_ok  = (ea[1:0] == 2'b00) && ({1'b0, ea} + 33'd4 <= 33'(MEM_BYTES));
    assign trial    = {drem_reg, dq_reg[31]} - {1'b0, dd_reg};

    assign q_pop     = (st_reg == S_IDLE) && q_valid;
    assign valid_out = (st_reg == S_DONE);
    assign next_pc   = npc_reg;
    assign reg_written = wr_reg;
    assign dest_index  = widx_reg;
    assign dest_value  = wval_reg;
    assign exception_code = exc_reg;

    // signed product from four registered 16x16 partials (unsigned, then corrected)
    always_comb
    begin
        prod_full = {phh_reg, 32'd0} + {16'd0, phl_reg, 16'd0} + {16'd0, plh_reg, 16'd0}
                    + {32'd0, pll_reg};
        prod_full = prod_full - ({a_reg[31] ? b_reg : 32'd0, 32'd0})
                              - ({b_reg[31] ? a_reg : 32'd0, 32'd0});
    end

    function automatic logic wr_next_f();
        logic w;
        logic [4:0] ix;
        w = 1'b0;
        ix = d_reg.rd;
        case (d_reg.kind)
            K_ADD: w = !ovf_add;
            K_SUB: w = !ovf_sub;
            K_AND, K_OR, K_XOR, K_SLT, K_SLL, K_SRL, K_ROTR, K_MFHI, K_MFLO: w = 1'b1;
            K_ADDI: begin w = !ovf_addi; ix = d_reg.rt; end
            K_LUI:  begin w = 1'b1; ix = d_reg.rt; end
            default: w = 1'b0;
        endcase
        return w && (ix != 5'd0);
    endfunction

    function automatic logic [31:0] wval_next_f();
        logic [31:0] v;
        logic [63:0] rr;
        rr = {b_reg, b_reg} >> d_reg.sh;
        case (d_reg.kind)
            K_ADD:  v = sum;
            K_SUB:  v = dif;
            K_AND:  v = a_reg & b_reg;
            K_OR:   v = a_reg | b_reg;
            K_XOR:  v = a_reg ^ b_reg;
            K_SLT:  v = {31'd0, $signed(a_reg) < $signed(b_reg)};
            K_SLL:  v = b_reg << d_reg.sh;
            K_SRL:  v = b_reg >> d_reg.sh;
            K_ROTR: v = rr[31:0];
            K_MFHI: v = hi_reg;
            K_MFLO: v = lo_reg;
            K_ADDI: v = ea;
            K_LUI:  v = lui;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] npc_next_f();
        logic [31:0] n;
        n = seq;
        case (d_reg.kind)
            K_JR:   n = a_reg;
            K_BEQ:  n = (a_reg == b_reg) ? btgt : seq;
            K_BNE:  n = (a_reg != b_reg) ? btgt : seq;
            K_BLEZ: n = ($signed(a_reg) <= 0) ? btgt : seq;
            K_BGTZ: n = ($signed(a_reg) > 0) ? btgt : seq;
            default: n = seq;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] exc_f();
        logic [1:0] e;
        case (d_reg.kind)
            K_ADD:   e = ovf_add ? EXC_OVF : EXC_NONE;
            K_SUB:   e = ovf_sub ? EXC_OVF : EXC_NONE;
            K_ADDI:  e = ovf_addi ? EXC_OVF : EXC_NONE;
            K_LW, K_SW: e = addr_ok ? EXC_NONE : EXC_ADDR;
            K_UNIMP: e = EXC_UNIMP;
            default: e = EXC_NONE;
        endcase
        return e;
    endfunction

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_CLR:  st_next = (clr_reg == AW'(WORDS - 1)) ? S_IDLE : S_CLR;
            S_IDLE: st_next = q_valid ? S_READ : S_IDLE;
            S_READ: st_next = S_EXEC;
            S_EXEC:
            begin
                case (d_reg.kind)
                    K_MULT: st_next = S_MUL2;
                    K_DIV:  st_next = S_DIVI;
                    K_LW:   st_next = addr_ok ? S_MEM : S_DONE;
                    K_SW:   st_next = addr_ok ? S_STW : S_DONE;
                    default: st_next = S_DONE;
                endcase
            end
            S_MUL2: st_next = S_DONE;
            S_DIVI: st_next = (dcnt_reg == 6'd32) ? S_DIVF : S_DIVI;
            S_DIVF: st_next = S_DONE;
            S_MEM:  st_next = S_LDW;
            S_LDW:  st_next = S_DONE;
            S_STW:  st_next = S_DONE;
            S_DONE: st_next = stall_out ? S_DONE : S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_CLR;
            clr_reg <= '0;
            pc_reg  <= '0;
            hi_reg  <= '0;
            lo_reg  <= '0;
            for (int i = 0; i < 32; i++)
                rf_reg[i] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == S_CLR)
                clr_reg <= clr_reg + AW'(1);
            if (st_reg == S_EXEC)
                pc_reg <= st_next == S_DONE ? npc_next_f() : pc_reg;
            if (st_reg == S_EXEC && d_reg.kind != K_MULT && d_reg.kind != K_DIV
                && d_reg.kind != K_LW && d_reg.kind != K_SW && wr_next_f())
                rf_reg[d_reg.kind inside {K_ADDI, K_LUI} ? d_reg.rt : d_reg.rd]
                    <= wval_next_f();
            if (st_reg == S_MUL2 || st_reg == S_DIVF || st_reg == S_LDW || st_reg == S_STW)
                pc_reg <= seq;
            if (st_reg == S_MUL2)
            begin
                hi_reg <= prod_full[63:32];
                lo_reg <= prod_full[31:0];
            end
            if (st_reg == S_DIVF)
            begin
                if (b_reg == 32'd0)
                begin
                    lo_reg <= 32'hFFFF_FFFF;
                    hi_reg <= a_reg;
                end
                else
                begin
                    lo_reg <= qneg_reg ? -dq_reg : dq_reg;
                    hi_reg <= rneg_reg ? -drem_reg : drem_reg;
                end
            end
            if (st_reg == S_LDW && d_reg.rt != 5'd0)
                rf_reg[d_reg.rt] <= rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            d_reg <= q_dec;
        if (st_reg == S_READ)
        begin
            a_reg <= rf_reg[d_reg.rs];
            b_reg <= rf_reg[d_reg.rt];
        end
        if (st_reg == S_EXEC)
        begin
            npc_reg  <= npc_next_f();
            exc_reg  <= exc_f();
            wr_reg   <= wr_next_f();
            widx_reg <= wr_next_f() ? ((d_reg.kind == K_ADDI || d_reg.kind == K_LUI)
                        ? d_reg.rt : d_reg.rd) : 5'd0;
            wval_reg <= wr_next_f() ? wval_next_f() : 32'd0;
            maddr_reg <= ea[AW+1:2];
            pll_reg <= a_reg[15:0] * b_reg[15:0];
            plh_reg <= a_reg[15:0] * b_reg[31:16];
            phl_reg <= a_reg[31:16] * b_reg[15:0];
            phh_reg <= a_reg[31:16] * b_reg[31:16];
            dq_reg   <= a_reg[31] ? -a_reg : a_reg;
            dd_reg   <= b_reg[31] ? -b_reg : b_reg;
            drem_reg <= 32'd0;
            dcnt_reg <= 6'd0;
            qneg_reg <= a_reg[31] ^ b_reg[31];
            rneg_reg <= a_reg[31];
        end
        if (st_reg == S_DIVI && dcnt_reg != 6'd32)
        begin
            dcnt_reg <= dcnt_reg + 6'd1;
            if (!trial[32])
            begin
                drem_reg <= trial[31:0];
                dq_reg   <= {dq_reg[30:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[30:0], dq_reg[31]};
                dq_reg   <= {dq_reg[30:0], 1'b0};
            end
        end
        if (st_reg == S_MEM)
            rdata_reg <= mem[maddr_reg];
        if (st_reg == S_LDW)
        begin
            wr_reg   <= d_reg.rt != 5'd0;
            widx_reg <= d_reg.rt;
            wval_reg <= d_reg.rt != 5'd0 ? rdata_reg : 32'd0;
        end
        if (st_reg == S_CLR)
            mem[clr_reg] <= 32'd0;
        else if (st_reg == S_STW)
            mem[maddr_reg] <= b_reg;
    end

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && stall_out |=> valid_out) else $error("result dropped");
    a_r0_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && !reg_written |-> dest_index == 5'd0 && dest_value == 32'd0)
        else $error("unwritten result carries data");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> st_reg == S_IDLE) else $error("pop while busy");

endmodule

>>> bench/tb_mips_subset_execute_step.sv
// Testbench for the MIPS subset executor: directed and random instruction streams,
// checked beat by beat against an internal architectural model. Depends on mse_pkg.
module tb_mips_subset_execute_step;
    timeunit 1ns;
    timeprecision 1ps;
    import mse_pkg::*;

    localparam int DMEM_BYTES = 4096;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic [4:0]  idx;
        logic [31:0] val;
        logic [1:0]  exc;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        valid_in = 1'b0;
    logic        stall_in;
    logic [31:0] instr_word = '0;
    logic        valid_out;
    logic        stall_out = 1'b0;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic [1:0]  exception_code;

    // Architectural copy of the core
    logic [31:0] arch_regs [32];
    logic [31:0] arch_hi, arch_lo, arch_pc;
    logic [7:0]  arch_mem [DMEM_BYTES];

    outcome_t    pending_outcomes [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    mips_subset_execute_step #(.MEM_BYTES(DMEM_BYTES)) u_dut (
        .clk(clk), .rst_n(rst_n), .valid_in(valid_in), .stall_in(stall_in),
        .instr_word(instr_word), .valid_out(valid_out), .stall_out(stall_out),
        .next_pc(next_pc), .reg_written(reg_written), .dest_index(dest_index),
        .dest_value(dest_value), .exception_code(exception_code)
    );

    always #10 clk = ~clk;

    // Compute the result of one instruction and advance the architectural state
    function automatic outcome_t execute_instr(logic [31:0] w);
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic [31:0] imm, a, b, seq, r, addr;
        logic signed [63:0] prod;
        outcome_t    o;
        op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
        sh = w[10:6]; fn = w[5:0];
        imm = {{16{w[15]}}, w[15:0]};
        a = arch_regs[rs]; b = arch_regs[rt];
        seq = arch_pc + 32'd4;
        o = '0;
        o.npc = seq;
        if (op == OP_SPECIAL) begin
            case (fn)
                FN_ADD: begin
                    r = a + b;
                    if (((a ^ r) & (b ^ r)) >> 31) o.exc = EXC_OVF;
                    else begin o.wr = 1'b1; o.idx = rd; o.val = r; end
                end
                FN_SUB: begin
                    r = a - b;
                    if (((a ^ b) & (a ^ r)) >> 31) o.exc = EXC_OVF;
                    else begin o.wr = 1'b1; o.idx = rd; o.val = r; end
                end
                FN_AND: begin o.wr = 1'b1; o.idx = rd; o.val = a & b; end
                FN_OR:  begin o.wr = 1'b1; o.idx = rd; o.val = a | b; end
                FN_XOR: begin o.wr = 1'b1; o.idx = rd; o.val = a ^ b; end
                FN_SLT: begin
                    o.wr = 1'b1; o.idx = rd; o.val = {31'd0, $signed(a) < $signed(b)};
                end
                FN_SLL: begin o.wr = 1'b1; o.idx = rd; o.val = b << sh; end
                FN_SRL: begin
                    o.wr = 1'b1; o.idx = rd;
                    o.val = rs[0] ? ((b >> sh) | (b << ((6'd32 - sh) & 6'd31))) : (b >> sh);
                end
                FN_MULT: begin
                    prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    arch_hi = prod[63:32]; arch_lo = prod[31:0];
                end
                FN_DIV: begin
                    if (b == 0) begin arch_lo = '1; arch_hi = a; end
                    else if (a == 32'h8000_0000 && b == '1) begin
                        arch_lo = 32'h8000_0000; arch_hi = '0;
                    end else begin
                        arch_lo = $signed(a) / $signed(b);
                        arch_hi = $signed(a) % $signed(b);
                    end
                end
                FN_MFHI: begin o.wr = 1'b1; o.idx = rd; o.val = arch_hi; end
                FN_MFLO: begin o.wr = 1'b1; o.idx = rd; o.val = arch_lo; end
                FN_JR:   o.npc = a;
                default: o.exc = EXC_UNIMP;
            endcase
        end else begin
            case (op)
                OP_ADDI: begin
                    r = a + imm;
                    if (((a ^ r) & (imm ^ r)) >> 31) o.exc = EXC_OVF;
                    else begin o.wr = 1'b1; o.idx = rt; o.val = r; end
                end
                OP_LUI: begin o.wr = 1'b1; o.idx = rt; o.val = {w[15:0], 16'h0}; end
                OP_LW, OP_SW: begin
                    addr = a + imm;
                    if (addr[1:0] != 0 || {1'b0, addr} + 33'd4 > DMEM_BYTES) o.exc = EXC_ADDR;
                    else if (op == OP_LW) begin
                        o.wr = 1'b1; o.idx = rt;
                        o.val = {arch_mem[addr], arch_mem[addr+1], arch_mem[addr+2],
                                 arch_mem[addr+3]};
                    end else begin
                        {arch_mem[addr], arch_mem[addr+1], arch_mem[addr+2],
                         arch_mem[addr+3]} = b;
                    end
                end
                OP_BEQ:  if (a == b) o.npc = seq + (imm << 2);
                OP_BNE:  if (a != b) o.npc = seq + (imm << 2);
                OP_BLEZ: if ($signed(a) <= 0) o.npc = seq + (imm << 2);
                OP_BGTZ: if ($signed(a) > 0) o.npc = seq + (imm << 2);
                default: o.exc = EXC_UNIMP;
            endcase
        end
        // Register zero stays zero: drop the write
        if (o.wr && o.idx == 0) o.wr = 1'b0;
        if (o.wr) arch_regs[o.idx] = o.val;
        else begin o.idx = '0; o.val = '0; end
        arch_pc = o.npc;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Send one beat: random idle beforehand, hold until accepted
    task automatic send_instr(logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            valid_in <= 1'b0;
            @(posedge clk);
        end
        valid_in <= 1'b1;
        instr_word <= w;
        pending_outcomes.push_back(execute_instr(w));
        do @(posedge clk); while (stall_in);
    endtask

    // Drop valid and hold off until every expected result is back
    task automatic wait_drained();
        valid_in <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
    endtask

    // Receiver stall pattern
    always @(posedge clk) stall_out <= ($urandom_range(99) < recv_stall_pct);

    // Result checker
    always @(posedge clk) begin
        outcome_t e;
        if (rst_n && valid_out && !stall_out) begin
            if (pending_outcomes.size() == 0) begin
                $display("unexpected result beat at %0t", $realtime);
                error_count++;
            end else begin
                e = pending_outcomes.pop_front();
                if (next_pc !== e.npc) report_mismatch("next_pc", next_pc, e.npc);
                if (reg_written !== e.wr)
                    report_mismatch("reg_written", 32'(reg_written), 32'(e.wr));
                if (dest_index !== e.idx)
                    report_mismatch("dest_index", 32'(dest_index), 32'(e.idx));
                if (dest_value !== e.val) report_mismatch("dest_value", dest_value, e.val);
                if (exception_code !== e.exc)
                    report_mismatch("exception_code", 32'(exception_code), 32'(e.exc));
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout");
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] r_type(logic [4:0] rs, rt, rd, sh, logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, rt, logic [15:0] im);
        return {op, rs, rt, im};
    endfunction

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(9) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    endfunction

    // Directed: extremes, overflow, address error, unimplemented, divide corners
    task automatic test_directed();
        send_instr(32'h0);                                         // NOP
        send_instr(i_type(OP_LUI, 5'd0, 5'd1, 16'h8000));          // r1 = 0x80000000
        send_instr(i_type(OP_ADDI, 5'd0, 5'd2, 16'hFFFF));         // r2 = -1
        send_instr(i_type(OP_LUI, 5'd0, 5'd3, 16'h7FFF));
        send_instr(i_type(OP_ADDI, 5'd3, 5'd3, 16'h7FFF));
        send_instr(i_type(OP_ADDI, 5'd3, 5'd3, 16'h7FFF));         // r3 = 0x7FFFFFFE
        send_instr(i_type(OP_ADDI, 5'd3, 5'd4, 16'h7FFF));         // overflow
        send_instr(r_type(5'd3, 5'd3, 5'd5, 5'd0, FN_ADD));        // overflow
        send_instr(r_type(5'd1, 5'd3, 5'd5, 5'd0, FN_SUB));        // overflow
        send_instr(r_type(5'd1, 5'd2, 5'd0, 5'd0, FN_DIV));        // division overflow
        send_instr(r_type(5'd0, 5'd0, 5'd6, 5'd0, FN_MFLO));
        send_instr(r_type(5'd0, 5'd0, 5'd6, 5'd0, FN_MFHI));
        send_instr(r_type(5'd3, 5'd0, 5'd0, 5'd0, FN_DIV));        // divide by zero
        send_instr(r_type(5'd0, 5'd0, 5'd7, 5'd0, FN_MFLO));
        send_instr(r_type(5'd1, 5'd1, 5'd0, 5'd0, FN_MULT));
        send_instr(r_type(5'd0, 5'd0, 5'd8, 5'd0, FN_MFHI));
        send_instr(r_type(5'h1F, 5'd1, 5'd9, 5'd31, FN_SRL));      // ROTR by 31
        send_instr(r_type(5'h1E, 5'd1, 5'd9, 5'd31, FN_SRL));      // SRL by 31
        send_instr(r_type(5'd0, 5'd2, 5'd10, 5'd31, FN_SLL));
        send_instr(r_type(5'd1, 5'd2, 5'd0, 5'd0, FN_SLT));        // write to r0 dropped
        send_instr(i_type(OP_SW, 5'd0, 5'd3, 16'h0FFC));           // top word
        send_instr(i_type(OP_LW, 5'd0, 5'd11, 16'h0FFC));
        send_instr(i_type(OP_LW, 5'd0, 5'd11, 16'h0FFE));          // misaligned
        send_instr(i_type(OP_SW, 5'd0, 5'd3, 16'h1000));           // out of range
        send_instr(32'h0C00_0000);                                 // JAL: unimplemented
        send_instr(r_type(5'd0, 5'd0, 5'd0, 5'd0, 6'h0C));         // SYSCALL
    endtask

    // Random instruction mix; mostly legal with memory addresses in range
    task automatic test_random(int count);
        logic [31:0] w;
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            if (k < 8) w = $urandom();
            else if (k < 14) w = i_type(OP_LUI, 5'd0, pick_reg(), 16'($urandom()));
            else if (k < 24) w = i_type(OP_ADDI, pick_reg(), pick_reg(), 16'($urandom()));
            else if (k < 32) w = i_type(($urandom_range(1) ? OP_LW : OP_SW), 5'd0, pick_reg(),
                                        16'($urandom_range(3)) == 0 ? 16'($urandom()) :
                                        16'($urandom_range(0, DMEM_BYTES/4 - 1) * 4));
            else if (k < 38) w = i_type(6'($urandom_range(OP_BEQ, OP_BGTZ)), pick_reg(),
                                        pick_reg(), 16'($urandom()));
            else if (k < 40) w = r_type(pick_reg(), 5'd0, 5'd0, 5'd0, FN_JR);
            else if (k < 44) w = r_type(pick_reg(), pick_reg(), 5'd0, 5'd0, FN_DIV);
            else begin
                case ($urandom_range(10))
                    0: w = {6'h0, 20'($urandom()), FN_ADD};
                    1: w = {6'h0, 20'($urandom()), FN_SUB};
                    2: w = {6'h0, 20'($urandom()), FN_AND};
                    3: w = {6'h0, 20'($urandom()), FN_OR};
                    4: w = {6'h0, 20'($urandom()), FN_XOR};
                    5: w = {6'h0, 20'($urandom()), FN_SLT};
                    6: w = {6'h0, 20'($urandom()), FN_SLL};
                    7: w = {6'h0, 20'($urandom()), FN_SRL};
                    8: w = {6'h0, 20'($urandom()), FN_MULT};
                    9: w = {6'h0, 20'($urandom()), FN_MFHI};
                    default: w = {6'h0, 20'($urandom()), FN_MFLO};
                endcase
            end
            send_instr(w);
        end
    endtask

    initial begin
        for (int i = 0; i < 32; i++) arch_regs[i] = '0;
        for (int i = 0; i < DMEM_BYTES; i++) arch_mem[i] = '0;
        arch_hi = '0; arch_lo = '0; arch_pc = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_drained();                 // hold off until everything is back
        test_random(360);
        send_idle_pct = 49;
        test_random(360);
        send_idle_pct = 0; recv_stall_pct = 49;
        test_random(360);
        send_idle_pct = 14; recv_stall_pct = 14;
        test_random(360);

        wait_drained();
        repeat (60) @(posedge clk);
        if (error_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
